// ===== rtl/core/tlpt_pkg.sv =====
package tlpt_pkg;

    localparam int TABLE_POOL = 16;
    localparam int IDX_W      = 10;
    localparam int ENTRIES    = 1 << IDX_W;
    localparam int VPN_W      = 20;
    localparam int FRAME_W    = 20;
    localparam int TBL_W      = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int NFT_W      = $clog2(TABLE_POOL + 1);
    localparam int LEAF_DEPTH = TABLE_POOL * ENTRIES;
    localparam int LEAF_AW    = $clog2(LEAF_DEPTH);

    localparam logic [1:0] CMD_MAP    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_UNMAP  = 2'd2;

    typedef enum logic [1:0] {
        OP_MAP,
        OP_LOOKUP,
        OP_UNMAP,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_LEAF
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [VPN_W-1:0]   virt_page;
        logic [FRAME_W-1:0] phys_frame;
        logic               writable;
        logic               kernel_only;
        logic               alloc_mark;
    } t_in_word;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] found_frame;
        logic               found_writable;
        logic               found_alloc;
        logic               found_kernel;
    } t_out_word;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   dir_idx;
        logic [IDX_W-1:0]   tab_idx;
        logic [FRAME_W-1:0] phys_frame;
        logic               writable;
        logic               kernel_only;
        logic               alloc_mark;
    } t_job;

    typedef struct packed {
        logic               present;
        logic [TBL_W-1:0]   table_num;
    } t_dir;

    typedef struct packed {
        logic               present;
        logic               writable;
        logic               kernel;
        logic               alloc;
        logic [FRAME_W-1:0] frame;
    } t_leaf;

    // back end -> front end
    typedef struct packed {
        logic take;
        logic clearing;
    } t_back_ctl;

endpackage

// ===== rtl/core/tlpt_ram.sv =====
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tlpt_front.sv =====
module tlpt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tlpt_pkg::t_in_word i_in_word,
    input  tlpt_pkg::t_back_ctl i_ctl,
    output logic               o_job_valid,
    output tlpt_pkg::t_job     o_job
);

    tlpt_pkg::t_job r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           accept;
    logic           take;
    tlpt_pkg::t_job job_in;

    always_comb begin
        job_in.dir_idx     = i_in_word.virt_page[2*tlpt_pkg::IDX_W-1:tlpt_pkg::IDX_W];
        job_in.tab_idx     = i_in_word.virt_page[tlpt_pkg::IDX_W-1:0];
        job_in.phys_frame  = i_in_word.phys_frame;
        job_in.writable    = i_in_word.writable;
        job_in.kernel_only = i_in_word.kernel_only;
        job_in.alloc_mark  = i_in_word.alloc_mark;
        case (i_in_word.cmd)
            tlpt_pkg::CMD_MAP:    job_in.op = tlpt_pkg::OP_MAP;
            tlpt_pkg::CMD_LOOKUP: job_in.op = tlpt_pkg::OP_LOOKUP;
            tlpt_pkg::CMD_UNMAP:  job_in.op = tlpt_pkg::OP_UNMAP;
            default:              job_in.op = tlpt_pkg::OP_NOP;
        endcase
    end

    // no words taken while the memories are being cleared
    assign full        = r_cnt[1] | i_ctl.clearing;
    assign accept      = push & ~full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd_ptr];
    assign take        = i_ctl.take & o_job_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (accept & ~take) begin
            n_cnt = r_cnt + 2'd1;
        end else if (take & ~accept) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= job_in;
        end
    end

endmodule

// ===== rtl/core/tlpt_back.sv =====
module tlpt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  tlpt_pkg::t_job      i_job,
    output tlpt_pkg::t_back_ctl o_ctl,
    output logic                empty,
    input  logic                pop,
    output tlpt_pkg::t_out_word o_out_word
);

    tlpt_pkg::t_state r_state;
    tlpt_pkg::t_state n_state;
    logic [tlpt_pkg::LEAF_AW-1:0] r_clr_addr;
    tlpt_pkg::t_job   r_job;
    logic [tlpt_pkg::NFT_W-1:0] r_nft;

    tlpt_pkg::t_out_word r_oq [2];
    logic       r_o_wr;
    logic       r_o_rd;
    logic [1:0] r_o_cnt;
    logic [1:0] n_o_cnt;

    logic                         take;
    logic                         dir_we;
    logic [tlpt_pkg::IDX_W-1:0]   dir_waddr;
    tlpt_pkg::t_dir               dir_wdata;
    logic [tlpt_pkg::IDX_W-1:0]   dir_raddr;
    tlpt_pkg::t_dir               dir_q;
    logic                         leaf_we;
    logic [tlpt_pkg::LEAF_AW-1:0] leaf_waddr;
    tlpt_pkg::t_leaf              leaf_wdata;
    logic [tlpt_pkg::LEAF_AW-1:0] leaf_raddr;
    tlpt_pkg::t_leaf              leaf_q;
    logic                         res_valid;
    tlpt_pkg::t_out_word          res_word;
    logic                         nft_inc;
    logic                         pool_left;
    logic                         out_pop;
    logic [tlpt_pkg::LEAF_AW-1:0] addr_old;
    logic [tlpt_pkg::LEAF_AW-1:0] addr_new;

    tlpt_ram #(
        .WIDTH ($bits(tlpt_pkg::t_dir)),
        .DEPTH (tlpt_pkg::ENTRIES)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_raddr (dir_raddr),
        .o_rdata (dir_q)
    );

    tlpt_ram #(
        .WIDTH ($bits(tlpt_pkg::t_leaf)),
        .DEPTH (tlpt_pkg::LEAF_DEPTH)
    ) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_raddr (leaf_raddr),
        .o_rdata (leaf_q)
    );

    assign pool_left = (r_nft < tlpt_pkg::NFT_W'(tlpt_pkg::TABLE_POOL));
    assign addr_old  = tlpt_pkg::LEAF_AW'({dir_q.table_num, r_job.tab_idx});
    assign addr_new  = tlpt_pkg::LEAF_AW'({tlpt_pkg::TBL_W'(r_nft), r_job.tab_idx});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlpt_pkg::ST_CLEAR: begin
                if (r_clr_addr == tlpt_pkg::LEAF_AW'(tlpt_pkg::LEAF_DEPTH - 1)) begin
                    n_state = tlpt_pkg::ST_IDLE;
                end
            end
            tlpt_pkg::ST_IDLE: begin
                if (i_job_valid & ~r_o_cnt[1]) begin
                    n_state = tlpt_pkg::ST_DIR;
                end
            end
            tlpt_pkg::ST_DIR: begin
                if (r_job.op == tlpt_pkg::OP_LOOKUP && dir_q.present) begin
                    n_state = tlpt_pkg::ST_LEAF;
                end else begin
                    n_state = tlpt_pkg::ST_IDLE;
                end
            end
            tlpt_pkg::ST_LEAF: n_state = tlpt_pkg::ST_IDLE;
            default:           n_state = tlpt_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        take       = 1'b0;
        dir_we     = 1'b0;
        dir_waddr  = r_job.dir_idx;
        dir_wdata  = '0;
        dir_raddr  = i_job.dir_idx;
        leaf_we    = 1'b0;
        leaf_waddr = addr_old;
        leaf_wdata = '0;
        leaf_raddr = addr_old;
        res_valid  = 1'b0;
        res_word   = '0;
        nft_inc    = 1'b0;
        case (r_state)
            tlpt_pkg::ST_CLEAR: begin
                dir_we     = 1'b1;
                dir_waddr  = r_clr_addr[tlpt_pkg::IDX_W-1:0];
                leaf_we    = 1'b1;
                leaf_waddr = r_clr_addr;
            end
            tlpt_pkg::ST_IDLE: begin
                take = i_job_valid & ~r_o_cnt[1];
            end
            tlpt_pkg::ST_DIR: begin
                case (r_job.op)
                    tlpt_pkg::OP_MAP: begin
                        leaf_wdata.present  = 1'b1;
                        leaf_wdata.writable = r_job.writable;
                        leaf_wdata.kernel   = r_job.kernel_only;
                        leaf_wdata.alloc    = r_job.alloc_mark;
                        leaf_wdata.frame    = r_job.phys_frame;
                        res_valid = 1'b1;
                        if (dir_q.present) begin
                            leaf_we     = 1'b1;
                            res_word.ok = 1'b1;
                        end else if (pool_left) begin
                            dir_we              = 1'b1;
                            dir_wdata.present   = 1'b1;
                            dir_wdata.table_num = tlpt_pkg::TBL_W'(r_nft);
                            leaf_we             = 1'b1;
                            leaf_waddr          = addr_new;
                            nft_inc             = 1'b1;
                            res_word.ok         = 1'b1;
                        end
                    end
                    tlpt_pkg::OP_LOOKUP: begin
                        res_valid = ~dir_q.present;
                    end
                    tlpt_pkg::OP_UNMAP: begin
                        // all-zero leaf: present bit drops, other bits unread until remap
                        leaf_we     = dir_q.present;
                        res_valid   = 1'b1;
                        res_word.ok = dir_q.present;
                    end
                    default: begin
                        res_valid = 1'b1;
                    end
                endcase
            end
            tlpt_pkg::ST_LEAF: begin
                res_valid = 1'b1;
                if (leaf_q.present) begin
                    res_word.ok             = 1'b1;
                    res_word.found_frame    = leaf_q.frame;
                    res_word.found_writable = leaf_q.writable;
                    res_word.found_alloc    = leaf_q.alloc;
                    res_word.found_kernel   = leaf_q.kernel;
                end
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    assign o_ctl.take     = take;
    assign o_ctl.clearing = (r_state == tlpt_pkg::ST_CLEAR);

    // result queue
    assign empty      = (r_o_cnt == 2'd0);
    assign out_pop    = pop & ~empty;
    assign o_out_word = r_oq[r_o_rd];

    always_comb begin
        n_o_cnt = r_o_cnt;
        if (res_valid & ~out_pop) begin
            n_o_cnt = r_o_cnt + 2'd1;
        end else if (out_pop & ~res_valid) begin
            n_o_cnt = r_o_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tlpt_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_nft      <= '0;
            r_o_wr     <= 1'b0;
            r_o_rd     <= 1'b0;
            r_o_cnt    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_o_cnt <= n_o_cnt;
            if (r_state == tlpt_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + tlpt_pkg::LEAF_AW'(1);
            end
            if (nft_inc) begin
                r_nft <= r_nft + tlpt_pkg::NFT_W'(1);
            end
            if (res_valid) begin
                r_o_wr <= ~r_o_wr;
            end
            if (out_pop) begin
                r_o_rd <= ~r_o_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
        if (res_valid) begin
            r_oq[r_o_wr] <= res_word;
        end
    end

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (r_o_cnt != 2'd2))
        else $error("result written into a full result queue");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nft <= tlpt_pkg::NFT_W'(tlpt_pkg::TABLE_POOL))
        else $error("table pool count out of range");

    a_take_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_state == tlpt_pkg::ST_DIR))
        else $error("taken word did not go to directory read");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlpt_pkg::ST_LEAF) |-> $past(r_state == tlpt_pkg::ST_DIR && !res_valid))
        else $error("lookup produced two results");

endmodule

// ===== rtl/core/two_level_page_table_engine.sv =====
// Channel   Ports                            Direction   Handshake
// input     push, full, i_in_word            in          push & ~full
// result    empty, pop, o_out_word           out         pop & ~empty
//
// In the back end an item passes a directory read, then decision and write;
// a lookup whose directory entry is present adds a dependent leaf read.
// The directory read and the leaf access go through the synchronous RAMs.
// After reset the RAMs are cleared one entry a cycle, over all TABLE_POOL * 1024
// leaf entries, during which full stays high.
// A two-word queue at each side lets input and result sides stall independently.
module two_level_page_table_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tlpt_pkg::t_in_word  i_in_word,
    output logic                empty,
    input  logic                pop,
    output tlpt_pkg::t_out_word o_out_word
);

    tlpt_pkg::t_back_ctl ctl;
    logic                job_valid;
    tlpt_pkg::t_job      job;

    tlpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .i_ctl       (ctl),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    tlpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_ctl       (ctl),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word)
    );

endmodule
